// File: hdl/cps_pkg.sv
package cps_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int IN_WIDTH       = 32;
  localparam int OUT_WIDTH      = 8;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int WIN_W          = 15;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_INT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_TOL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_INT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_TOL  = 3'd4;

  localparam logic [15:0]      DEBOUNCE_RST = 16'd200;
  localparam logic [WIN_W-1:0] ON_INT_RST   = 15'd250;
  localparam logic [WIN_W-1:0] ON_TOL_RST   = 15'd75;
  localparam logic [WIN_W-1:0] OFF_INT_RST  = 15'd500;
  localparam logic [WIN_W-1:0] OFF_TOL_RST  = 15'd100;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_OFF  = 2'd2;

  typedef struct packed {
    logic       accepted;
    logic [1:0] event_code;
    logic       switch_on;
  } result_t;

  // interval is long when it reaches 32768 ms or more
  function automatic logic in_window(input logic long_gap, input logic [WIN_W-1:0] diff,
                                     input logic [WIN_W-1:0] nominal,
                                     input logic [WIN_W-1:0] tol);
    logic signed [WIN_W:0] dev;
    logic        [WIN_W:0] mag;
    dev = $signed({1'b0, diff}) - $signed({1'b0, nominal});
    mag = dev[WIN_W] ? (WIN_W+1)'(-dev) : (WIN_W+1)'(dev);
    return !long_gap && (mag <= {1'b0, tol});
  endfunction

endpackage

// File: hdl/clap_pattern_switch.sv
// clap pattern switch
// input channel in_*: one word per rising sound edge, in_tdata holds the
// 32-bit wrapping millisecond timestamp edge_time_ms
// output channel out_*: exactly one word per input word, in the same order
// a word accepted at an edge goes to the input register, then to the result
// register that drives out_tvalid when the receiver is not stalling (two register stages)
// throughput: one word per cycle while the receiver is not stalling; the history
// and switch state update in the same cycle a word moves from the input register
// to the result register, so the next word sees them without a gap
// a stalled receiver holds the result register; one more word waits in the
// input register, then in_tready drops until out_tready returns
// configuration: cfg_wen writes cfg_wdata to register cfg_addr at a clock
// edge; unknown indexes are ignored; write only while the block is idle
// reset (rst_n low, synchronous): history cleared to zeros, switch off,
// registers back to defaults, both stages empty
module clap_pattern_switch #(
  parameter int TIME_WIDTH = cps_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cps_pkg::IN_WIDTH-1:0]   in_tdata,   // edge_time_ms
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cps_pkg::OUT_WIDTH-1:0]  out_tdata,  // accepted, event_code, switch_on, zeros
  input  logic                           cfg_wen,
  input  logic [cps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WW = cps_pkg::WIN_W;

  logic [15:0]           debounce_r;
  logic [WW-1:0]         on_int_r, on_tol_r, off_int_r, off_tol_r;
  logic                  s1_valid_r;
  logic [TIME_WIDTH-1:0] s1_time_r;
  logic                  out_valid_r;
  cps_pkg::result_t      res_r, res_nxt;
  logic [TIME_WIDTH-1:0] hist0_r, hist1_r, hist2_r;
  logic [TIME_WIDTH-1:0] hist0_nxt, hist1_nxt, hist2_nxt;
  logic                  drive_r, drive_nxt;

  logic                  out_free, s1_move;
  logic [TIME_WIDTH-1:0] gap_new, gap_old;
  logic                  keep, on_a, on_b, off_a;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // debounce and pattern check on the word in the input register
  always_comb begin
    keep    = (s1_time_r - hist0_r) >= TIME_WIDTH'(debounce_r);
    gap_new = s1_time_r - hist0_r;
    gap_old = hist0_r - hist1_r;
    on_a  = cps_pkg::in_window(|gap_new[TIME_WIDTH-1:WW], gap_new[WW-1:0], on_int_r, on_tol_r);
    on_b  = cps_pkg::in_window(|gap_old[TIME_WIDTH-1:WW], gap_old[WW-1:0], on_int_r, on_tol_r);
    off_a = cps_pkg::in_window(|gap_new[TIME_WIDTH-1:WW], gap_new[WW-1:0], off_int_r, off_tol_r);

    hist0_nxt = hist0_r;
    hist1_nxt = hist1_r;
    hist2_nxt = hist2_r;
    drive_nxt = drive_r;
    res_nxt.accepted   = keep;
    res_nxt.event_code = cps_pkg::EV_NONE;
    if (keep) begin
      hist0_nxt = s1_time_r;
      hist1_nxt = hist0_r;
      hist2_nxt = hist1_r;
      if (on_a && on_b) begin
        res_nxt.event_code = cps_pkg::EV_ON;
        drive_nxt = 1'b1;
      end else if (off_a) begin
        res_nxt.event_code = cps_pkg::EV_OFF;
        drive_nxt = 1'b0;
      end
      if (res_nxt.event_code != cps_pkg::EV_NONE) begin
        hist0_nxt = '0;
        hist1_nxt = '0;
        hist2_nxt = '0;
      end
    end
    res_nxt.switch_on = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= cps_pkg::DEBOUNCE_RST;
      on_int_r   <= cps_pkg::ON_INT_RST;
      on_tol_r   <= cps_pkg::ON_TOL_RST;
      off_int_r  <= cps_pkg::OFF_INT_RST;
      off_tol_r  <= cps_pkg::OFF_TOL_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        cps_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata;
        cps_pkg::REG_ON_INT:   on_int_r   <= cfg_wdata[WW-1:0];
        cps_pkg::REG_ON_TOL:   on_tol_r   <= cfg_wdata[WW-1:0];
        cps_pkg::REG_OFF_INT:  off_int_r  <= cfg_wdata[WW-1:0];
        cps_pkg::REG_OFF_TOL:  off_tol_r  <= cfg_wdata[WW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist0_r     <= '0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      drive_r     <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        hist0_r     <= hist0_nxt;
        hist1_r     <= hist1_nxt;
        hist2_r     <= hist2_nxt;
        drive_r     <= drive_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_time_r <= TIME_WIDTH'(in_tdata);
    end
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.switch_on, res_r.event_code, res_r.accepted};

endmodule

// File: bench/clap_pattern_switch_tb.sv
module clap_pattern_switch_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int STAGE_COUNT = 12;
  localparam int EDGES_PER_STAGE = 88;
  localparam logic [31:0] LONG_GAP = 32'd32768;
  localparam logic [cps_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  class clap_scoreboard;
    logic [15:0]               debounce_ms;
    logic [cps_pkg::WIN_W-1:0] on_int;
    logic [cps_pkg::WIN_W-1:0] on_tol;
    logic [cps_pkg::WIN_W-1:0] off_int;
    logic [cps_pkg::WIN_W-1:0] off_tol;
    logic [31:0]               history [3];
    logic                      switch_state;
    cps_pkg::result_t          expected_q [$];
    int                        errors;

    function new();
      debounce_ms  = cps_pkg::DEBOUNCE_RST;
      on_int       = cps_pkg::ON_INT_RST;
      on_tol       = cps_pkg::ON_TOL_RST;
      off_int      = cps_pkg::OFF_INT_RST;
      off_tol      = cps_pkg::OFF_TOL_RST;
      history[0]   = '0;
      history[1]   = '0;
      history[2]   = '0;
      switch_state = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(input logic [cps_pkg::CFG_ADDR_W-1:0] idx,
                            input logic [15:0] val);
      case (idx)
        cps_pkg::REG_DEBOUNCE: debounce_ms = val;
        cps_pkg::REG_ON_INT:   on_int = val[cps_pkg::WIN_W-1:0];
        cps_pkg::REG_ON_TOL:   on_tol = val[cps_pkg::WIN_W-1:0];
        cps_pkg::REG_OFF_INT:  off_int = val[cps_pkg::WIN_W-1:0];
        cps_pkg::REG_OFF_TOL:  off_tol = val[cps_pkg::WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit gap_fits(input logic [31:0] later, input logic [31:0] earlier,
                          input logic [cps_pkg::WIN_W-1:0] nominal,
                          input logic [cps_pkg::WIN_W-1:0] tol);
      logic [31:0] diff;
      int          dev;
      diff = later - earlier;
      if (diff >= LONG_GAP) return 1'b0;
      dev = int'(diff) - int'(nominal);
      if (dev < 0) dev = -dev;
      return dev <= int'(tol);
    endfunction

    function void note_edge(input logic [31:0] t);
      cps_pkg::result_t r;
      logic [31:0]      since;
      r = '0;
      since = t - history[0];
      if (since >= 32'(debounce_ms)) begin
        r.accepted = 1'b1;
        history[2] = history[1];
        history[1] = history[0];
        history[0] = t;
        if (gap_fits(history[0], history[1], on_int, on_tol) &&
            gap_fits(history[1], history[2], on_int, on_tol)) begin
          r.event_code = cps_pkg::EV_ON;
          switch_state = 1'b1;
        end else if (gap_fits(history[0], history[1], off_int, off_tol)) begin
          r.event_code = cps_pkg::EV_OFF;
          switch_state = 1'b0;
        end
        if (r.event_code != cps_pkg::EV_NONE) begin
          history[0] = '0;
          history[1] = '0;
          history[2] = '0;
        end
      end
      r.switch_on = switch_state;
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic [cps_pkg::OUT_WIDTH-1:0] word);
      cps_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", word);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (word[0] !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, word[0]);
        errors++;
      end
      if (word[2:1] !== want.event_code) begin
        $error("event_code: expected %0d, got %0d", want.event_code, word[2:1]);
        errors++;
      end
      if (word[3] !== want.switch_on) begin
        $error("switch_on: expected %0d, got %0d", want.switch_on, word[3]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [cps_pkg::IN_WIDTH-1:0]   in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cps_pkg::OUT_WIDTH-1:0]  out_tdata;
  logic                           cfg_wen = 1'b0;
  logic [cps_pkg::CFG_ADDR_W-1:0] cfg_addr = cps_pkg::REG_DEBOUNCE;
  logic [cps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  clap_scoreboard board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int edges_sent = 0;
  int quiet_cycles = 0;

  clap_pattern_switch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // edge_time_ms
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // accepted, event_code, switch_on, zeros
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wen || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_edge(input logic [31:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_edge(t);
    edges_sent++;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [cps_pkg::CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // bit 15 of the window registers is toggled at random, it must be dropped
  task automatic set_timing(input logic [15:0] deb, input logic [cps_pkg::WIN_W-1:0] oi,
                            input logic [cps_pkg::WIN_W-1:0] ot,
                            input logic [cps_pkg::WIN_W-1:0] fi,
                            input logic [cps_pkg::WIN_W-1:0] ft);
    cfg_write(cps_pkg::REG_DEBOUNCE, deb);
    cfg_write(cps_pkg::REG_ON_INT, {1'($urandom_range(0, 1)), oi});
    cfg_write(cps_pkg::REG_ON_TOL, {1'($urandom_range(0, 1)), ot});
    cfg_write(cps_pkg::REG_OFF_INT, {1'($urandom_range(0, 1)), fi});
    cfg_write(cps_pkg::REG_OFF_TOL, {1'($urandom_range(0, 1)), ft});
    cfg_write(REG_SPARE, 16'($urandom()));
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] near_gap(input logic [cps_pkg::WIN_W-1:0] nominal,
                                           input logic [cps_pkg::WIN_W-1:0] tol);
    int spread;
    spread = int'(tol) + 4;
    return 32'(int'(nominal) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic clap_stream(input int target);
    logic [31:0] now;
    int          kind;
    now = $urandom();
    while (edges_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        now += 32'($urandom_range(0, 40000));
        send_edge(now);
        repeat (2) begin
          if ($urandom_range(0, 3) == 0) send_edge(now + $urandom_range(0, board.debounce_ms));
          now += near_gap(board.on_int, board.on_tol);
          send_edge(now);
        end
      end else if (kind < 70) begin
        now += 32'($urandom_range(0, 40000));
        send_edge(now);
        if ($urandom_range(0, 3) == 0) send_edge(now + $urandom_range(0, board.debounce_ms));
        now += near_gap(board.off_int, board.off_tol);
        send_edge(now);
      end else if (kind < 85) begin
        send_edge(now + $urandom_range(0, board.debounce_ms));
      end else if (kind < 95) begin
        now += 32'($urandom_range(0, 70000));
        send_edge(now);
      end else begin
        now = $urandom();
        send_edge(now);
      end
    end
  endtask

  initial begin
    logic [31:0] directed [$];
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bounce off zero history, on pattern, repeated on, wrap to off, long gaps,
    // off at window edge while off, on at window edge, drops near wrap
    directed = '{32'd100, 32'd200, 32'd450, 32'd250, 32'd500,
                 32'hFFFF_FF00, 32'h0000_00F4, 32'h0000_8000, 32'h0000_FFFF,
                 32'h0001_00C6, 32'h0001_0257, 32'd1000, 32'd1325, 32'd1650,
                 32'd175, 32'hFFFF_FFFF, 32'h0000_00AF, 32'h0000_012C,
                 32'h0000_0300, 32'h0000_0500};
    foreach (directed[i]) send_edge(directed[i]);
    in_tvalid <= 1'b0;
    drain();

    for (int stage = 0; stage < STAGE_COUNT; stage++) begin
      case (stage)
        0: set_timing(16'd200, 15'd250, 15'd75, 15'd500, 15'd100);
        1: set_timing(16'd0, 15'd0, 15'd0, 15'd0, 15'd0);
        2: set_timing(16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        3: set_timing(16'd100, 15'd300, 15'd50, 15'd300, 15'd80);
        4: set_timing(16'd0, 15'h7FFF, 15'd5, 15'd32000, 15'd800);
        default: set_timing(16'($urandom_range(0, 400)), 15'($urandom_range(0, 2000)),
                            15'($urandom_range(0, 300)), 15'($urandom_range(0, 4000)),
                            15'($urandom_range(0, 500)));
      endcase
      case (stage % 4)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 60; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 60; end
        default: begin send_idle_pct <= 19; stall_pct <= 19; end
      endcase
      @(posedge clk);
      clap_stream(edges_sent + EDGES_PER_STAGE);
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
